/* hw/rtl/spirv_spec_constant_patcher_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the spec-constant patcher
// Shared property forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef SPIRV_SPEC_CONSTANT_PATCHER_UNIT_DEFINES_SVH
`define SPIRV_SPEC_CONSTANT_PATCHER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SSCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sscp: same-cycle property failed");

// next-cycle implication, disabled while reset is asserted
`define SSCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sscp: next-cycle property failed");

`endif

/* hw/rtl/sscp_pkg.sv */
// ---------------------------------------------------------------------------
// sscp_pkg
// Types and constants for the SPIR-V spec-constant patcher.
// ---------------------------------------------------------------------------
package sscp_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0] half_t;
	typedef logic [0:0]  cfg_idx_t;
	typedef logic [2:0]  hdr_cnt_t;

	// register indexes on the configuration port
	localparam cfg_idx_t CFG_SPEC_ID   = 1'b0;
	localparam cfg_idx_t CFG_NEW_VALUE = 1'b1;

	// pass kind, carried in tuser on the input side
	localparam logic MODE_SCAN  = 1'b0;
	localparam logic MODE_PATCH = 1'b1;

	localparam half_t    OP_DECORATE        = 16'd71;
	localparam half_t    OP_SPEC_CONSTANT   = 16'd50;
	localparam word_t    DECORATION_SPEC_ID = 32'd1;
	localparam hdr_cnt_t HEADER_WORDS       = 3'd5;
	localparam half_t    MIN_WORDS          = 16'd4;

	localparam word_t SPEC_ID_RESET   = 32'd1;
	localparam word_t NEW_VALUE_RESET = 32'd0;

endpackage

/* hw/rtl/spirv_spec_constant_patcher_unit.sv */
// ---------------------------------------------------------------------------
// spirv_spec_constant_patcher_unit
// Walks a SPIR-V word stream twice: the scan pass finds the id decorated with
// the configured SpecId, the patch pass rewrites that spec constant's literal.
// ---------------------------------------------------------------------------
// Path: a patch-pass word moves from the input register to the result
//   register and m_tdata; scan-pass words give no result. Throughput: one
//   word per cycle unless a patch-pass word waits on a stalled result; the
//   walker updates once per word in the single stage between the registers.
// Reset: arst_n clears the walker, the found target, both valid flags and sets
//   spec_id to 1 and new_value to 0.
// ---------------------------------------------------------------------------
module spirv_spec_constant_patcher_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_wr_en,
	input  sscp_pkg::cfg_idx_t     cfg_index,
	input  sscp_pkg::word_t        cfg_data,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [31:0]            s_tdata,   // [31:0] word
	input  logic                   s_tuser,   // [0] mode (0 scan, 1 patch)
	input  logic                   s_tlast,
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [31:0]            m_tdata,   // [31:0] word_out
	output logic                   m_tuser,   // [0] replaced
	output logic                   m_tlast
);
	import sscp_pkg::*;

	// configuration registers
	word_t spec_id_q;
	word_t new_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_id_q   <= SPEC_ID_RESET;
			new_value_q <= NEW_VALUE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SPEC_ID:   spec_id_q   <= cfg_data;
				CFG_NEW_VALUE: new_value_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// input register
	logic  valid_s1;
	word_t word_s1;
	logic  mode_s1;
	logic  last_s1;

	// result register
	logic  valid_s2;
	word_t word_s2;
	logic  repl_s2;
	logic  last_s2;

	// A scan-pass word needs no room downstream; a patch-pass word waits for
	// the result register to be free or drained in this same cycle.
	logic s2_free;
	logic adv_s1;

	assign s2_free  = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && ((mode_s1 == MODE_SCAN) || s2_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1 <= s_tdata;
			mode_s1 <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	// walker state
	hdr_cnt_t hdr_cnt_q;
	half_t    offset_q;
	half_t    length_q;
	half_t    opcode_q;
	logic     second_ok_q;
	word_t    cand_id_q;
	word_t    target_id_q;
	logic     target_found_q;
	logic     finished_q;

	hdr_cnt_t hdr_cnt_d;
	half_t    offset_d;
	half_t    length_d;
	half_t    opcode_d;
	logic     second_ok_d;
	word_t    cand_id_d;
	word_t    target_id_d;
	logic     target_found_d;
	logic     finished_d;
	word_t    result_word;
	logic     result_repl;

	logic        is_patch;
	half_t       lead_len;
	logic        long_enough;
	logic [16:0] offset_inc;

	assign is_patch    = (mode_s1 == MODE_PATCH);
	assign lead_len    = word_s1[31:16];
	assign long_enough = (length_q >= MIN_WORDS);
	assign offset_inc  = {1'b0, offset_q} + 17'd1;

	always_comb begin
		hdr_cnt_d      = hdr_cnt_q;
		offset_d       = offset_q;
		length_d       = length_q;
		opcode_d       = opcode_q;
		second_ok_d    = second_ok_q;
		cand_id_d      = cand_id_q;
		target_id_d    = target_id_q;
		target_found_d = target_found_q;
		finished_d     = finished_q;
		result_word    = word_s1;
		result_repl    = 1'b0;

		// first scan word of a pass drops any target from an earlier scan
		if (!is_patch && (hdr_cnt_q == '0)) begin
			target_found_d = 1'b0;
		end

		if (hdr_cnt_q < HEADER_WORDS) begin
			hdr_cnt_d = hdr_cnt_q + 3'd1;
		end else if (!finished_q) begin
			if (offset_q == '0) begin
				// leading word: count in the upper half, opcode in the lower
				if (lead_len == '0) begin
					finished_d = 1'b1;
				end else begin
					length_d    = lead_len;
					opcode_d    = word_s1[15:0];
					second_ok_d = 1'b0;
					offset_d    = (lead_len > 16'd1) ? 16'd1 : 16'd0;
				end
			end else begin
				if (!is_patch && (opcode_q == OP_DECORATE) && long_enough) begin
					if (offset_q == 16'd1) begin
						cand_id_d = word_s1;
					end else if (offset_q == 16'd2) begin
						second_ok_d = (word_s1 == DECORATION_SPEC_ID);
					end else if ((offset_q == 16'd3) && second_ok_q &&
							(word_s1 == spec_id_q)) begin
						target_id_d    = cand_id_q;
						target_found_d = 1'b1;
						finished_d     = 1'b1;
					end
				end else if (is_patch && (opcode_q == OP_SPEC_CONSTANT) && long_enough &&
						target_found_q) begin
					if (offset_q == 16'd2) begin
						second_ok_d = (word_s1 == target_id_q);
					end else if ((offset_q == 16'd3) && second_ok_q) begin
						result_word = new_value_q;
						result_repl = 1'b1;
						finished_d  = 1'b1;
					end
				end
				// advance within the instruction, wrap to the next leading word
				offset_d = (offset_inc >= {1'b0, length_q}) ? 16'd0 : offset_inc[15:0];
			end
		end

		// end of pass: clear the walker, keep the found target
		if (last_s1) begin
			hdr_cnt_d   = '0;
			offset_d    = '0;
			length_d    = '0;
			opcode_d    = '0;
			second_ok_d = 1'b0;
			cand_id_d   = '0;
			finished_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q      <= '0;
			offset_q       <= '0;
			length_q       <= '0;
			opcode_q       <= '0;
			second_ok_q    <= 1'b0;
			cand_id_q      <= '0;
			target_id_q    <= '0;
			target_found_q <= 1'b0;
			finished_q     <= 1'b0;
		end else if (adv_s1) begin
			hdr_cnt_q      <= hdr_cnt_d;
			offset_q       <= offset_d;
			length_q       <= length_d;
			opcode_q       <= opcode_d;
			second_ok_q    <= second_ok_d;
			cand_id_q      <= cand_id_d;
			target_id_q    <= target_id_d;
			target_found_q <= target_found_d;
			finished_q     <= finished_d;
		end
	end

	// result register: load on a patch-pass word, drop on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && is_patch) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_patch) begin
			word_s2 <= result_word;
			repl_s2 <= result_repl;
			last_s2 <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = word_s2;
	assign m_tuser  = repl_s2;
	assign m_tlast  = last_s2;

endmodule

/* hw/rtl/sscp_checker.sv */
// ---------------------------------------------------------------------------
// sscp_checker
// Port-level checks on the spec-constant patcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "spirv_spec_constant_patcher_unit_defines.svh"

module sscp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_wr_en,
	input sscp_pkg::cfg_idx_t cfg_index,
	input sscp_pkg::word_t    cfg_data,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [31:0]        m_tdata,
	input logic               m_tuser,
	input logic               m_tlast
);
	import sscp_pkg::*;

	// shadow of the replacement value as written on the port
	word_t new_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_value_q <= NEW_VALUE_RESET;
		end else if (cfg_wr_en && (cfg_index == CFG_NEW_VALUE)) begin
			new_value_q <= cfg_data;
		end
	end

	// a stalled result holds
	`SSCP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// the input side only stalls behind a stalled result
	`SSCP_ASSERT_NOW(a_in_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready)

	// a patched word carries the configured value
	`SSCP_ASSERT_NOW(a_patch_value, clk, arst_n, m_tvalid && m_tuser, m_tdata == new_value_q)

endmodule

bind spirv_spec_constant_patcher_unit sscp_checker u_sscp_checker (.*);

/* tb/sv/sscp_result_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sscp_result_checker
// Watches the configuration port and both streams of the spec-constant
// patcher, predicts every patch-pass word and compares the results in order.
// ---------------------------------------------------------------------------
module sscp_result_checker
	import sscp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr_en,
	input  cfg_idx_t cfg_index,
	input  word_t    cfg_data,
	input  logic     s_tvalid,
	input  logic     s_tready,
	input  logic     [31:0] s_tdata,   // [31:0] word
	input  logic     s_tuser,          // [0] mode
	input  logic     s_tlast,
	input  logic     m_tvalid,
	input  logic     m_tready,
	input  logic     [31:0] m_tdata,   // [31:0] word_out
	input  logic     m_tuser,          // [0] replaced
	input  logic     m_tlast,
	output int       n_errors,
	output int       n_pending,
	output int       n_results,
	output int       n_patched
);

	typedef struct packed {
		word_t word_out;
		logic  replaced;
		logic  last_out;
	} patched_word_t;

	patched_word_t pending_words[$];

	// configuration copy
	word_t    want_spec_id;
	word_t    patch_value;
	// walker copy
	hdr_cnt_t hdr_seen;
	half_t    pos;
	half_t    len;
	half_t    opc;
	logic     op2_ok;
	word_t    cand_id;
	word_t    tgt_id;
	logic     tgt_ok;
	logic     parse_done;

	function automatic void clear_walker();
		hdr_seen   = '0;
		pos        = '0;
		len        = '0;
		opc        = '0;
		op2_ok     = 1'b0;
		cand_id    = '0;
		parse_done = 1'b0;
	endfunction

	// advance the walker by one word; returns 1 when the word leaves as a result
	function automatic logic walk_word(input logic mode, input word_t w, input logic lst,
			output patched_word_t res);
		logic        patch;
		logic        long_ok;
		logic [16:0] nxt;
		patch        = (mode == MODE_PATCH);
		res.word_out = w;
		res.replaced = 1'b0;
		res.last_out = lst;
		if (!patch && hdr_seen == '0)
			tgt_ok = 1'b0;
		if (hdr_seen < HEADER_WORDS) begin
			hdr_seen = hdr_seen + 3'd1;
		end else if (!parse_done) begin
			if (pos == '0) begin
				if (w[31:16] == '0) begin
					parse_done = 1'b1;
				end else begin
					len    = w[31:16];
					opc    = w[15:0];
					op2_ok = 1'b0;
					pos    = (w[31:16] > 16'd1) ? 16'd1 : 16'd0;
				end
			end else begin
				long_ok = (len >= MIN_WORDS);
				if (!patch && opc == OP_DECORATE && long_ok) begin
					if (pos == 16'd1) begin
						cand_id = w;
					end else if (pos == 16'd2) begin
						op2_ok = (w == DECORATION_SPEC_ID);
					end else if (pos == 16'd3 && op2_ok && w == want_spec_id) begin
						tgt_id     = cand_id;
						tgt_ok     = 1'b1;
						parse_done = 1'b1;
					end
				end else if (patch && opc == OP_SPEC_CONSTANT && long_ok && tgt_ok) begin
					if (pos == 16'd2) begin
						op2_ok = (w == tgt_id);
					end else if (pos == 16'd3 && op2_ok) begin
						res.word_out = patch_value;
						res.replaced = 1'b1;
						parse_done   = 1'b1;
					end
				end
				nxt = {1'b0, pos} + 17'd1;
				pos = (nxt >= {1'b0, len}) ? 16'd0 : nxt[15:0];
			end
		end
		if (lst)
			clear_walker();
		return patch;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		patched_word_t got;
		patched_word_t want;
		if (!arst_n) begin
			want_spec_id = SPEC_ID_RESET;
			patch_value  = NEW_VALUE_RESET;
			clear_walker();
			tgt_id       = '0;
			tgt_ok       = 1'b0;
			pending_words.delete();
			n_errors     = 0;
			n_pending    = 0;
			n_results    = 0;
			n_patched    = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SPEC_ID:   want_spec_id = cfg_data;
					CFG_NEW_VALUE: patch_value  = cfg_data;
					default: ;
				endcase
			end
			// results first: nothing accepted at this edge can leave at it
			if (m_tvalid && m_tready) begin
				n_results++;
				if (pending_words.size() == 0) begin
					$error("unexpected result: word_out %h replaced %b last_out %b",
						m_tdata, m_tuser, m_tlast);
					n_errors++;
				end else begin
					want = pending_words.pop_front();
					if (m_tdata !== want.word_out) begin
						$error("word_out: expected %h, got %h", want.word_out, m_tdata);
						n_errors++;
					end
					if (m_tuser !== want.replaced) begin
						$error("replaced: expected %b, got %b", want.replaced, m_tuser);
						n_errors++;
					end
					if (m_tlast !== want.last_out) begin
						$error("last_out: expected %b, got %b", want.last_out, m_tlast);
						n_errors++;
					end
					if (want.replaced)
						n_patched++;
				end
			end
			if (s_tvalid && s_tready) begin
				if (walk_word(s_tuser, s_tdata, s_tlast, got))
					pending_words.push_back(got);
			end
			n_pending = pending_words.size();
		end
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives SPIR-V word streams through the spec-constant patcher: most modules
// go through a scan pass and a patch pass under changing SpecId and patch
// values, mixed with truncated modules and noise. A side checker predicts and
// compares every emitted word; this top makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module testbench;
	import sscp_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     cfg_wr_en;
	cfg_idx_t cfg_index;
	word_t    cfg_data;
	logic     s_tvalid;
	logic     s_tready;
	logic     [31:0] s_tdata;   // [31:0] word
	logic     s_tuser;          // [0] mode (0 scan, 1 patch)
	logic     s_tlast;
	logic     m_tvalid;
	logic     m_tready;
	logic     [31:0] m_tdata;   // [31:0] word_out
	logic     m_tuser;          // [0] replaced
	logic     m_tlast;

	int errors;
	int pending;
	int results;
	int patched;

	// stimulus bookkeeping
	word_t image[$];
	word_t cur_spec_id;
	int    words_sent;
	int    scan_sent;
	int    patch_sent;
	int    passes;
	int    burst_left;
	logic  in_taken;
	bit    hold_done;

	spirv_spec_constant_patcher_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	sscp_result_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.n_errors  (errors),
		.n_pending (pending),
		.n_results (results),
		.n_patched (patched)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop: far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("spirv_spec_constant_patcher_unit: mismatch");
		$finish;
	end

	// Latch the input handshake at the rising edge so the driver can read it
	// at the following falling edge without racing the block.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_taken <= 1'b0;
		else
			in_taken <= s_tvalid && s_tready;
	end

	// Receiver: switch between stall styles (always ready, coin toss, mostly
	// stalled, one stall in three). Once the run is under way, hold off once,
	// while a patch-pass word is on offer, so the block backs up into its input.
	initial begin
		int cyc;
		int style;
		int hold_left;
		cyc       = 0;
		style     = 0;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 80 == 0)
				style = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && words_sent >= 200 && pending > 0 && s_tvalid &&
					(s_tuser == MODE_PATCH)) begin
				hold_left = 300;
				hold_done = 1'b1;
				m_tready <= 1'b0;
			end else begin
				case (style)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (cyc % 3 != 0);
				endcase
			end
		end
	end

	// Offer one word and hold it until its transfer. The sender works in
	// bursts; when a burst runs out, drop valid and wait before offering the word.
	task automatic push_word(input logic mode, input word_t w, input logic lst);
		int gap;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= mode;
		s_tlast  <= lst;
		do
			@(negedge clk);
		while (!in_taken);
		burst_left--;
		words_sent++;
		if (mode == MODE_PATCH)
			patch_sent++;
		else
			scan_sent++;
	endtask

	// Send the whole image as one pass, last on its final word.
	task automatic send_pass(input logic mode);
		foreach (image[i])
			push_word(mode, image[i], i == image.size() - 1);
		passes++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input word_t v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Reprogram only once the block is idle: drain every expected word, then
	// allow the pipeline to empty of scan words, which leave nothing behind.
	task automatic set_config(input word_t spec, input word_t value);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(CFG_SPEC_ID, spec);
		write_reg(CFG_NEW_VALUE, value);
		cur_spec_id = spec;
	endtask

	function automatic word_t pick_value();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return 32'hFFFF_FFFF;
			2:       return word_t'($urandom_range(0, 8));
			default: return word_t'($urandom());
		endcase
	endfunction

	// Build a small module: random header, then a mix of SpecId decorations,
	// spec constants sharing one id, instructions too short to match, foreign
	// instructions (some with a huge count) and the odd zero-count stop word.
	// Now and then truncate the image, sometimes inside the header.
	task automatic build_module(input word_t sid);
		word_t shared_id;
		half_t len;
		half_t opc;
		int    n_instr;
		int    extra;
		int    keep;
		image.delete();
		repeat (5) image.push_back(word_t'($urandom()));
		shared_id = word_t'($urandom_range(1, 60));
		n_instr   = $urandom_range(1, 6);
		repeat (n_instr) begin
			extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			len   = half_t'(4 + extra);
			case ($urandom_range(0, 11))
				0, 1, 2, 3: begin
					image.push_back({len, OP_DECORATE});
					image.push_back(($urandom_range(0, 3) != 0) ? shared_id
						: word_t'($urandom_range(1, 60)));
					image.push_back(($urandom_range(0, 7) != 0) ? DECORATION_SPEC_ID
						: word_t'($urandom()));
					image.push_back(($urandom_range(0, 3) != 0) ? sid : word_t'($urandom()));
					repeat (extra) image.push_back(word_t'($urandom()));
				end
				4, 5, 6, 7: begin
					image.push_back({len, OP_SPEC_CONSTANT});
					image.push_back(word_t'($urandom_range(1, 60)));
					image.push_back(($urandom_range(0, 3) != 0) ? shared_id
						: word_t'($urandom_range(1, 60)));
					image.push_back(word_t'($urandom()));
					repeat (extra) image.push_back(word_t'($urandom()));
				end
				8: begin
					// right opcode and contents, but fewer than four words
					len = half_t'($urandom_range(1, 3));
					opc = $urandom_range(0, 1) ? OP_DECORATE : OP_SPEC_CONSTANT;
					image.push_back({len, opc});
					if (len > 16'd1)
						image.push_back(shared_id);
					if (len > 16'd2)
						image.push_back((opc == OP_DECORATE) ? DECORATION_SPEC_ID : shared_id);
				end
				9, 10: begin
					len = ($urandom_range(0, 7) == 0) ? 16'hFFFF : half_t'($urandom_range(1, 5));
					image.push_back({len, half_t'($urandom())});
					repeat ($urandom_range(0, 4)) image.push_back(word_t'($urandom()));
				end
				default: begin
					image.push_back({16'h0000, half_t'($urandom())});
				end
			endcase
		end
		if ($urandom_range(0, 4) == 0) begin
			keep = $urandom_range(1, image.size());
			while (image.size() > keep)
				void'(image.pop_back());
		end
	endtask

	initial begin
		int    phase;
		int    choice;
		int    n_noise;
		word_t spec;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = CFG_SPEC_ID;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = MODE_SCAN;
		s_tlast     = 1'b0;
		cur_spec_id = SPEC_ID_RESET;
		words_sent  = 0;
		scan_sent   = 0;
		patch_sent  = 0;
		passes      = 0;
		burst_left  = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: a module that ends inside the header, both passes, under
		// the reset settings; nothing to patch, words pass through.
		image = '{32'hFFFF_FFFF, 32'h0000_0000};
		send_pass(MODE_SCAN);
		send_pass(MODE_PATCH);

		// Directed: all-ones SpecId and patch value; the scan pass decorates
		// id 7, the patch pass carries the spec constant of id 7.
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		image = '{32'h0723_0203, 32'h0001_0000, 32'h0000_0000, 32'h0000_0040,
			32'h0000_0000, {16'd4, OP_DECORATE}, 32'd7, DECORATION_SPEC_ID,
			32'hFFFF_FFFF};
		send_pass(MODE_SCAN);
		image = '{32'h0723_0203, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0040,
			32'h0000_0000, {16'd4, OP_SPEC_CONSTANT}, 32'd3, 32'd7, 32'h1234_5678};
		send_pass(MODE_PATCH);

		// Random part: mostly scan-then-patch pairs of well-formed modules,
		// with lone passes and mixed-mode noise between them.
		phase = 0;
		while (words_sent < 630) begin
			if (phase == 0)
				set_config('0, '0);
			else if ($urandom_range(0, 2) == 0)
				set_config(pick_value(), pick_value());
			phase++;
			choice = $urandom_range(0, 19);
			if (choice < 2) begin
				// noise: random words, random modes, stray lasts; end on a last
				n_noise = $urandom_range(3, 20);
				for (int k = 0; k < n_noise; k++)
					push_word(1'($urandom_range(0, 1)), word_t'($urandom()),
						(k == n_noise - 1) || ($urandom_range(0, 7) == 0));
			end else begin
				spec = ($urandom_range(0, 9) < 7) ? cur_spec_id : pick_value();
				build_module(spec);
				if (choice < 17) begin
					send_pass(MODE_SCAN);
					send_pass(MODE_PATCH);
				end else if (choice < 19) begin
					send_pass(MODE_PATCH);
				end else begin
					send_pass(MODE_SCAN);
				end
			end
		end

		// Drain and let the pipeline settle before the verdict.
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d words (%0d scan, %0d patch) in %0d passes; receiver hold-off %s.",
			words_sent, scan_sent, patch_sent, passes, hold_done ? "done" : "not reached");
		$display("Checked %0d result words, %0d of them patched literals.", results, patched);
		if (errors == 0 && pending == 0)
			$display("spirv_spec_constant_patcher_unit: match");
		else
			$display("spirv_spec_constant_patcher_unit: mismatch");
		$finish;
	end

endmodule
